// ===== hdl/bezpd_pkg.sv =====
// Shared types and constants for the Bezier point and derivative evaluator.
// Holds command codes and stream field layout; no dependencies.
`default_nettype none

package bezpd_pkg;

  // Command codes carried in s_axis_tuser
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_POS  = 2'd1;
  localparam logic [1:0] CMD_VEL  = 2'd2;
  localparam logic [1:0] CMD_ACC  = 2'd3;

  // Stream widths
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 32;

  // Input tdata field layout, lowest bit first
  localparam int unsigned IDX_LSB = 0;
  localparam int unsigned PX_LSB  = 3;
  localparam int unsigned PY_LSB  = 19;
  localparam int unsigned PT_LSB  = 35;
  localparam int unsigned PT_W    = 17;

  typedef logic signed [15:0] coord_t;

endpackage

`default_nettype wire

// ===== hdl/bezier_point_and_derivative_eval.sv =====
// Bezier point / derivative evaluator top level (de Casteljau, fixed point).
// Depends on bezpd_pkg for command codes and stream layout.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes curve_degree; always
//   ready. Write it only while no evaluate request is in flight.
//   s_axis carries requests: tuser = command, tdata = point_index, point_x,
//   point_y, param_t. A load request writes one control point slot and gives
//   no result. Position, velocity and acceleration requests each give one
//   result on m_axis: tdata = result_x, result_y, tuser = saturated.
//   An evaluate request runs S steps on one shared multiplier, S being the
//   difference steps (n for velocity, n-1 for acceleration) plus the
//   de Casteljau lerps of the remaining degree m, m*(m+1)/2. Each step
//   issues x then y on consecutive cycles; products are registered for
//   write-back, then the round state fills the output register.
//   s_axis_tready is low from acceptance of an evaluate request until its
//   result sits in the output register.
//   A result waits in the output register while m_axis_tready is low; the
//   next request is taken meanwhile, and its result waits until that slot
//   frees up.
//   Reset (rst, synchronous) sets curve_degree to 3 and drops any result;
//   control point slots are not cleared and must be loaded before use.
`default_nettype none

module bezier_point_and_derivative_eval
  import bezpd_pkg::*;
#(
  parameter int MAX_DEGREE  = 7,
  parameter int T_FRAC_BITS = 16
) (
  input  wire                    clk,
  input  wire                    rst,
  // configuration write: curve_degree
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [2:0]             cfg_data,
  // requests
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: point_index[2:0], point_x[18:3], point_y[34:19], param_t[51:35], zero pad
  input  wire  [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: command[1:0]
  input  wire  [CMD_W-1:0]       s_axis_tuser,
  // results
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  // tdata: result_x[15:0], result_y[31:16]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: saturated[0]
  output logic [0:0]             m_axis_tuser
);

  localparam int F   = T_FRAC_BITS;
  localparam int NP  = MAX_DEGREE + 1;            // control point slots
  localparam int QD  = (NP < 3) ? 3 : NP;         // work queue depth
  localparam int IW  = $clog2(QD);
  localparam int CW  = $clog2(MAX_DEGREE + 2);    // holds counts 0..NP
  localparam int AW  = 16 + F;                    // accumulator width
  localparam int MAW = AW + 1;                    // multiplier A operand
  localparam int MBW = F + 2;                     // multiplier B operand (signed)
  localparam int PW  = MAW + MBW;                 // product width
  localparam int TCW = (F + 1 > PT_W) ? F + 2 : PT_W + 1;

  localparam logic [F:0]           T_ONE = {1'b1, {F{1'b0}}};
  localparam logic [AW:0]          HALF  = (AW + 1)'(1) << (F - 1);
  localparam logic signed [PW-1:0] PMAX  = PW'(32767);
  localparam logic signed [PW-1:0] PMIN  = PW'(-32768);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_ROUND = 2'd3;

  localparam logic [1:0] PH_LERP  = 2'd0;
  localparam logic [1:0] PH_DIFF1 = 2'd1;
  localparam logic [1:0] PH_DIFF2 = 2'd2;

  // Round half away from zero to s16; top bit flags saturation
  function automatic logic [16:0] round_s16(input logic signed [AW-1:0] v);
    logic [AW:0] mag;
    logic [AW:0] r;
    logic [16:0] res;
    if (!v[AW-1]) begin
      mag = {1'b0, v};
    end else begin
      mag = -{v[AW-1], v};
    end
    r = (mag + HALF) >> F;
    if (!v[AW-1]) begin
      if (r > (AW + 1)'(32767)) res = {1'b1, 16'h7FFF};
      else                      res = {1'b0, r[15:0]};
    end else begin
      if (r > (AW + 1)'(32768)) res = {1'b1, 16'h8000};
      else                      res = {1'b0, 16'(~r[15:0] + 16'd1)};
    end
    return res;
  endfunction

  // Control and payload registers
  logic [1:0]             state;
  logic [2:0]             curve_degree;
  coord_t                 px [NP];
  coord_t                 py [NP];
  logic signed [AW-1:0]   qx [QD];
  logic signed [AW-1:0]   qy [QD];
  logic signed [AW-1:0]   qx_next [QD];
  logic signed [AW-1:0]   qy_next [QD];
  logic [1:0]             phase;
  logic [CW-1:0]          cnt;
  logic [CW-1:0]          pos;
  logic                   issue_ax;
  logic [F:0]             t_r;
  logic [F:0]             kmul;
  logic                   sat_flag;
  logic signed [PW-1:0]   prod_r;
  logic signed [AW-1:0]   base_r;
  logic                   wb_vld;
  logic                   wb_ax;
  logic                   wb_lerp;
  logic [1:0]             wb_shift;
  logic [IW-1:0]          wb_idx;
  coord_t                 out_x;
  coord_t                 out_y;
  logic                   out_sat;
  logic                   out_valid;

  // Request fields
  logic [1:0]  cmd;
  logic [2:0]  in_idx;
  coord_t      in_px;
  coord_t      in_py;
  logic [PT_W-1:0] in_t;
  logic        acc_req;
  logic        load_en;
  logic        eval_en;

  assign cmd    = s_axis_tuser;
  assign in_idx = s_axis_tdata[IDX_LSB +: 3];
  assign in_px  = s_axis_tdata[PX_LSB +: 16];
  assign in_py  = s_axis_tdata[PY_LSB +: 16];
  assign in_t   = s_axis_tdata[PT_LSB +: PT_W];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign acc_req       = s_axis_tvalid && s_axis_tready;
  assign load_en       = acc_req && (cmd == CMD_LOAD);
  assign eval_en       = acc_req && (cmd != CMD_LOAD);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_y, out_x};
  assign m_axis_tuser  = out_sat;

  // Effective degree, clamped parameter and derivative scale
  logic [3:0]     n4;
  logic [CW-1:0]  n_eff;
  logic [F:0]     t_clamp;
  logic [7:0]     k_acc;
  logic           zero_res;

  always_comb begin
    n4 = ({1'b0, curve_degree} > 4'(MAX_DEGREE)) ? 4'(MAX_DEGREE) : {1'b0, curve_degree};
    n_eff = CW'(n4);
    t_clamp = (TCW'(in_t) > TCW'(T_ONE)) ? T_ONE : (F + 1)'(in_t);
    k_acc = 8'(n4) * (8'(n4) - 8'd1);
    zero_res = ((cmd == CMD_VEL) && (n4 < 4'd1)) || ((cmd == CMD_ACC) && (n4 < 4'd2));
  end

  // Issue side: operand select and step bookkeeping
  logic signed [AW-1:0]  q0, q1, q2;
  logic signed [16:0]    d1;
  logic signed [17:0]    d2;
  logic signed [MAW-1:0] mult_a;
  logic signed [MBW-1:0] mult_b;
  logic signed [PW-1:0]  prod_c;
  logic [CW-1:0]         drop;
  logic                  step_last;
  logic [CW-1:0]         step_shift;
  logic [CW-1:0]         cnt_after;
  logic                  run_done;

  always_comb begin
    q0 = issue_ax ? qy[0] : qx[0];
    q1 = issue_ax ? qy[1] : qx[1];
    q2 = issue_ax ? qy[2] : qx[2];
    d1 = 17'(signed'(q1[AW-1:F])) - 17'(signed'(q0[AW-1:F]));
    d2 = 18'(signed'(q2[AW-1:F])) - (18'(signed'(q1[AW-1:F])) <<< 1)
         + 18'(signed'(q0[AW-1:F]));
    case (phase)
      PH_DIFF1: mult_a = MAW'(d1);
      PH_DIFF2: mult_a = MAW'(d2);
      default:  mult_a = {q1[AW-1], q1} - {q0[AW-1], q0};
    endcase
    mult_b = (phase == PH_LERP) ? signed'({1'b0, t_r}) : signed'({1'b0, kmul});
    drop = (phase == PH_DIFF2) ? CW'(2) : CW'(1);
    step_last = (pos == cnt - CW'(1) - drop);
    step_shift = step_last ? drop + CW'(1) : CW'(1);
    cnt_after = step_last ? cnt - drop : cnt;
    run_done = issue_ax && step_last && (cnt_after == CW'(1));
  end

  // Shared multiplier
  assign prod_c = mult_a * mult_b;

  // Write-back value: lerp sum or saturated difference point
  logic signed [PW-1:0] prod_sh;
  logic signed [AW-1:0] wb_val;
  logic                 wb_sat;

  always_comb begin
    prod_sh = prod_r >>> F;
    wb_sat = 1'b0;
    if (wb_lerp) begin
      wb_val = base_r + AW'(prod_sh);
    end else if (prod_r > PMAX) begin
      wb_val = {16'sh7FFF, {F{1'b0}}};
      wb_sat = 1'b1;
    end else if (prod_r < PMIN) begin
      wb_val = {16'sh8000, {F{1'b0}}};
      wb_sat = 1'b1;
    end else begin
      wb_val = {prod_r[15:0], {F{1'b0}}};
    end
  end

  // Work queues: fill on a new request, pop and append on write-back
  always_comb begin
    for (int j = 0; j < QD; j++) begin
      qx_next[j] = qx[j];
      qy_next[j] = qy[j];
    end
    if (eval_en) begin
      for (int j = 0; j < QD; j++) begin
        if (zero_res || j >= NP) begin
          qx_next[j] = '0;
          qy_next[j] = '0;
        end else begin
          qx_next[j] = {px[j % NP], {F{1'b0}}};
          qy_next[j] = {py[j % NP], {F{1'b0}}};
        end
      end
    end else if (wb_vld) begin
      for (int j = 0; j < QD; j++) begin
        case (wb_shift)
          2'd1: begin
            qx_next[j] = qx[(j + 1) % QD];
            qy_next[j] = qy[(j + 1) % QD];
          end
          2'd2: begin
            qx_next[j] = qx[(j + 2) % QD];
            qy_next[j] = qy[(j + 2) % QD];
          end
          default: begin
            qx_next[j] = qx[(j + 3) % QD];
            qy_next[j] = qy[(j + 3) % QD];
          end
        endcase
        if (wb_ax) begin
          qx_next[j] = qx[j];
        end else begin
          qy_next[j] = qy[j];
        end
        if (IW'(j) == wb_idx) begin
          if (wb_ax) qy_next[j] = wb_val;
          else       qx_next[j] = wb_val;
        end
      end
    end
  end

  // Rounded final values
  logic [16:0] rnd_x;
  logic [16:0] rnd_y;
  logic        out_free;

  assign rnd_x    = round_s16(qx[0]);
  assign rnd_y    = round_s16(qy[0]);
  assign out_free = !out_valid || m_axis_tready;

  // Payload registers
  always_ff @(posedge clk) begin
    for (int j = 0; j < QD; j++) begin
      qx[j] <= qx_next[j];
      qy[j] <= qy_next[j];
    end
    for (int j = 0; j < NP; j++) begin
      if (load_en && (4'(in_idx) == 4'(j))) begin
        px[j] <= in_px;
        py[j] <= in_py;
      end
    end
    if (eval_en) begin
      t_r  <= t_clamp;
      kmul <= (cmd == CMD_ACC) ? (F + 1)'(k_acc) : (F + 1)'(n4);
    end
    if (state == S_RUN) begin
      prod_r   <= prod_c;
      base_r   <= q0;
      wb_ax    <= issue_ax;
      wb_lerp  <= (phase == PH_LERP);
      wb_shift <= 2'(step_shift);
      wb_idx   <= IW'(cnt - step_shift);
    end
    if (state == S_ROUND && out_free) begin
      out_x   <= rnd_x[15:0];
      out_y   <= rnd_y[15:0];
      out_sat <= sat_flag | rnd_x[16] | rnd_y[16];
    end
  end

  // Sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      curve_degree <= 3'd3;
      out_valid    <= 1'b0;
      wb_vld       <= 1'b0;
      issue_ax     <= 1'b0;
      sat_flag     <= 1'b0;
      phase        <= PH_LERP;
      cnt          <= '0;
      pos          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        curve_degree <= cfg_data;
      end
      wb_vld <= (state == S_RUN);
      // collect difference-point clipping
      if (wb_vld && wb_sat) begin
        sat_flag <= 1'b1;
      end
      // load a finished result, or drop a taken one
      if (state == S_ROUND && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (eval_en) begin
            sat_flag <= 1'b0;
            issue_ax <= 1'b0;
            pos      <= '0;
            cnt      <= zero_res ? CW'(1) : n_eff + CW'(1);
            case (cmd)
              CMD_VEL: phase <= PH_DIFF1;
              CMD_ACC: phase <= PH_DIFF2;
              default: phase <= PH_LERP;
            endcase
            state <= (zero_res || n4 == 4'd0) ? S_ROUND : S_RUN;
          end
        end
        S_RUN: begin
          issue_ax <= !issue_ax;
          // advance the step after its y half is issued
          if (issue_ax) begin
            cnt   <= cnt_after;
            pos   <= step_last ? '0 : pos + CW'(1);
            phase <= step_last ? PH_LERP : phase;
          end
          if (run_done) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_ROUND;
        end
        S_ROUND: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for bezier_point_and_derivative_eval: predicts every
// position, velocity and acceleration result and compares it on m_axis.
// Depends on bezpd_pkg and the evaluator RTL only.

module tb;
  import bezpd_pkg::*;

  localparam int MAX_DEG       = 7;
  localparam int FRAC          = 16;
  localparam longint T_ONE     = 64'sd1 << FRAC;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASES        = 11;
  localparam int PHASE_ITEMS   = 100;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   sat;
  } curve_result_t;

  // Tracks control points and degree, works out each evaluate result
  class curve_tracker;
    coord_t        ctrl_x[MAX_DEG+1];
    coord_t        ctrl_y[MAX_DEG+1];
    logic [2:0]    degree;
    curve_result_t owed_results[$];
    int unsigned   error_count;

    function new();
      degree      = 3'd3;
      error_count = 0;
      foreach (ctrl_x[i]) begin
        ctrl_x[i] = '0;
        ctrl_y[i] = '0;
      end
    endfunction

    function void set_degree(logic [2:0] d);
      degree = d;
    endfunction

    function int unsigned outstanding();
      return owed_results.size();
    endfunction

    function coord_t clamp_s16(int v, inout bit flag);
      if (v > 32767) begin
        flag = 1'b1;
        return 16'sh7fff;
      end
      if (v < -32768) begin
        flag = 1'b1;
        return 16'sh8000;
      end
      return coord_t'(v);
    endfunction

    // de Casteljau over pts[0..m], floor on every lerp, round half away at the end
    function coord_t de_casteljau(int pts[MAX_DEG+1], int m, longint t, inout bit flag);
      longint acc[MAX_DEG+1];
      longint v;
      longint r;
      int res;
      for (int i = 0; i <= m; i++) acc[i] = longint'(pts[i]) <<< FRAC;
      for (int j = 1; j <= m; j++)
        for (int i = 0; i + j <= m; i++)
          acc[i] = ((T_ONE - t) * acc[i] + t * acc[i+1]) >>> FRAC;
      v = acc[0];
      if (v >= 0) begin
        r   = (v + (T_ONE >>> 1)) >>> FRAC;
        res = (r > 32767) ? 32768 : int'(r);
      end else begin
        r   = (-v + (T_ONE >>> 1)) >>> FRAC;
        res = (r > 32768) ? -32769 : -int'(r);
      end
      return clamp_s16(res, flag);
    endfunction

    // One axis of a position, velocity or acceleration request
    function coord_t axis_value(coord_t pts[MAX_DEG+1], logic [1:0] cmd, int n, longint t,
                                inout bit flag);
      int q[MAX_DEG+1];
      int k;
      foreach (q[i]) q[i] = 0;
      case (cmd)
        CMD_POS: begin
          foreach (q[i]) q[i] = int'(pts[i]);
          return de_casteljau(q, n, t, flag);
        end
        CMD_VEL: begin
          if (n < 1) return '0;
          for (int i = 0; i < n; i++)
            q[i] = clamp_s16(n * (int'(pts[i+1]) - int'(pts[i])), flag);
          return de_casteljau(q, n - 1, t, flag);
        end
        default: begin
          if (n < 2) return '0;
          k = n * (n - 1);
          for (int i = 0; i + 1 < n; i++)
            q[i] = clamp_s16(k * (int'(pts[i+2]) - 2 * int'(pts[i+1]) + int'(pts[i])),
                             flag);
          return de_casteljau(q, n - 2, t, flag);
        end
      endcase
    endfunction

    function void note_request(logic [1:0] cmd, logic [2:0] idx, coord_t px, coord_t py,
                               logic [16:0] t_param);
      curve_result_t r;
      bit flag;
      int n;
      longint t;
      if (cmd == CMD_LOAD) begin
        if (idx <= MAX_DEG) begin
          ctrl_x[idx] = px;
          ctrl_y[idx] = py;
        end
        return;
      end
      n    = (degree > MAX_DEG) ? MAX_DEG : int'(degree);
      t    = (longint'(t_param) > T_ONE) ? T_ONE : longint'(t_param);
      flag = 1'b0;
      r.x  = axis_value(ctrl_x, cmd, n, t, flag);
      r.y  = axis_value(ctrl_y, cmd, n, t, flag);
      r.sat = flag;
      owed_results.push_back(r);
    endfunction

    function void check_result(coord_t x, coord_t y, logic sat);
      curve_result_t e;
      if (owed_results.size() == 0) begin
        $display("%0t: result with nothing pending: x=%0d y=%0d sat=%0b", $time, x, y, sat);
        error_count++;
        return;
      end
      e = owed_results.pop_front();
      if (x !== e.x) begin
        $display("%0t: result_x mismatch: expected %0d, actual %0d", $time, e.x, x);
        error_count++;
      end
      if (y !== e.y) begin
        $display("%0t: result_y mismatch: expected %0d, actual %0d", $time, e.y, y);
        error_count++;
      end
      if (sat !== e.sat) begin
        $display("%0t: saturated mismatch: expected %0b, actual %0b", $time, e.sat, sat);
        error_count++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [2:0]             cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  curve_tracker curve;
  bit           tx_steady = 1'b0;
  bit           rx_steady = 1'b0;
  int unsigned  stall_left = 0;
  int unsigned  cycle_count = 0;

  bezier_point_and_derivative_eval #(
    .MAX_DEGREE (MAX_DEG),
    .T_FRAC_BITS(FRAC)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 48);
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return coord_t'(int'($urandom_range(0, 64)) - 32);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] pick_param();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'(T_ONE);
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // Sample every handshake at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) curve.set_degree(cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        curve.note_request(s_axis_tuser, s_axis_tdata[IDX_LSB +: 3],
                           s_axis_tdata[PX_LSB +: 16], s_axis_tdata[PY_LSB +: 16],
                           s_axis_tdata[PT_LSB +: PT_W]);
      if (m_axis_tvalid && m_axis_tready)
        curve.check_result(m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser[0]);
    end
  end

  // Stall the result side at random, or hold ready high in steady stretches
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
      m_axis_tready <= 1'b0;
      stall_left    <= pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Present one request and hold it until accepted; enter and leave at a falling edge
  task automatic send_request(input logic [1:0] cmd, input logic [2:0] idx,
                              input coord_t px, input coord_t py, input logic [16:0] t_param);
    logic [IN_TDATA_W-1:0] data;
    int unsigned gap;
    data                   = '0;
    data[IDX_LSB +: 3]     = idx;
    data[PX_LSB +: 16]     = px;
    data[PY_LSB +: 16]     = py;
    data[PT_LSB +: PT_W]   = t_param;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic send_random_request();
    logic [1:0] cmd;
    cmd = ($urandom_range(0, 99) < 30) ? CMD_LOAD : 2'($urandom_range(1, 3));
    send_request(cmd, 3'($urandom_range(0, 7)), pick_coord(), pick_coord(), pick_param());
  endtask

  // Drain pending results, let the block settle, then write curve_degree
  task automatic write_degree(input logic [2:0] d);
    s_axis_tvalid <= 1'b0;
    while (curve.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** bezier_point_and_derivative_eval: FAILED **");
    $finish;
  end

  initial begin
    curve = new();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Load every slot, several with extremes; alternating signs force saturated differences
    send_request(CMD_LOAD, 3'd0, 16'sh7fff, 16'sh8000, 17'd0);
    send_request(CMD_LOAD, 3'd1, 16'sh8000, 16'sh7fff, 17'd0);
    send_request(CMD_LOAD, 3'd2, 16'sd0, -16'sd1, 17'd0);
    send_request(CMD_LOAD, 3'd3, -16'sd1, 16'sd0, 17'd0);
    send_request(CMD_LOAD, 3'd4, 16'sd1, 16'sd100, 17'd0);
    send_request(CMD_LOAD, 3'd5, 16'sd12345, -16'sd12345, 17'd0);
    send_request(CMD_LOAD, 3'd6, -16'sd20000, 16'sd20000, 17'd0);
    send_request(CMD_LOAD, 3'd7, 16'sh7fff, 16'sh8000, 17'd0);

    // Reset degree: ends of t, clamped t, midpoints, both derivatives
    send_request(CMD_POS, 3'd0, '0, '0, 17'd0);
    send_request(CMD_POS, 3'd0, '0, '0, 17'd65536);
    send_request(CMD_POS, 3'd7, 16'sh7fff, 16'sh8000, 17'd131071);
    send_request(CMD_POS, 3'd0, '0, '0, 17'd32768);
    send_request(CMD_VEL, 3'd0, '0, '0, 17'd0);
    send_request(CMD_ACC, 3'd0, '0, '0, 17'd65536);
    send_request(CMD_VEL, 3'd0, '0, '0, 17'd49152);

    // Degree zero: point 0 exactly, both derivatives zero
    write_degree(3'd0);
    send_request(CMD_POS, 3'd0, '0, '0, 17'd40000);
    send_request(CMD_VEL, 3'd0, '0, '0, 17'd40000);
    send_request(CMD_ACC, 3'd0, '0, '0, 17'd40000);

    // Degree one: acceleration still zero
    write_degree(3'd1);
    send_request(CMD_VEL, 3'd0, '0, '0, 17'd32768);
    send_request(CMD_ACC, 3'd0, '0, '0, 17'd32768);

    // Top degree
    write_degree(3'd7);
    send_request(CMD_POS, 3'd0, '0, '0, 17'd1);
    send_request(CMD_VEL, 3'd0, '0, '0, 17'd65535);
    send_request(CMD_ACC, 3'd0, '0, '0, 17'd30000);

    // Random phases, each at its own degree and idling pattern
    for (int p = 0; p < PHASES; p++) begin
      write_degree((p == 0) ? 3'd7 : (p == 1) ? 3'd0 : 3'($urandom_range(0, 7)));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) send_random_request();
    end

    // Drain and settle
    s_axis_tvalid <= 1'b0;
    while (curve.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (curve.error_count == 0) begin
      $display("** bezier_point_and_derivative_eval: PASSED **");
    end else begin
      $display("** bezier_point_and_derivative_eval: FAILED **");
    end
    $finish;
  end

endmodule
